// ----- rtl/core/krg_pkg.sv -----
// Package for the key group reorder block: payload types, register indexes,
// sequencer states and the fixed field widths. No dependencies.
`default_nettype none

package krg_pkg;

  localparam int CP_W   = 21;
  localparam int REP_W  = 8;
  localparam int IDX_W  = 3;
  localparam int USE_W  = 3;

  // Configuration register indexes; key n sits at CFG_KEY_0 + n.
  localparam logic [IDX_W-1:0] CFG_KEY_0       = 3'd0;
  localparam logic [IDX_W-1:0] CFG_KEYS_IN_USE = 3'd6;
  localparam logic [IDX_W-1:0] CFG_DEDUP_ON    = 3'd7;

  localparam logic [USE_W-1:0] KEYS_IN_USE_RESET = 3'd1;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  out_code_point;
    logic [REP_W-1:0] repeat_res;
    logic             last_of_run;
    logic             string_done;
    logic             was_modified;
  } out_item_t;

  // Mode bits handed from the register file to the sequencer.
  typedef struct packed {
    logic [USE_W-1:0] active;
    logic             dedup;
  } cfg_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_SETTLE,
    ST_DELIM
  } krg_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/krg_stream_if.sv -----
// Valid/ready stream interface used for the input and result channels.
// The payload type is set per instance; no dependencies.
`default_nettype none

interface krg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/key_group_reorder.sv -----
// Top level of the key group reorder block: configuration registers,
// sequencer and result output register. Depends on krg_pkg, krg_stream_if,
// krg_cfg and krg_seq.
//
// Usage: code points of a string arrive one per transfer on in_ch, with
// end_of_string set on the last one. A code point that matches an active key
// (lowest key index wins) only bumps that key's count. Any other code point,
// or the end of the string, settles the open group: every key with a nonzero
// count is sent on out_ch in key order with its count (or 1 under dedup),
// followed by the delimiter when there is one. last_of_run marks the final
// result of an input transfer; string_done and was_modified mark the final
// result of the string.
// Timing: one item at a time. in_ch.ready is high only while the sequencer
// is idle. An item is taken, then compared against the active keys in turn
// by the shared key comparator until a hit, then either a count is updated
// or, for a delimiter, it is sent; a settle walks all NUM_KEYS counts.
// Each result shows up on out_ch the cycle after the sequencer produces it.
// A stalled receiver holds the result register; the sequencer waits only
// when it has a new result and the register is still full. Configuration is
// written on cfg_we, cfg_idx, cfg_data; the user must write it only while no
// item is in work, as the block does not enforce this. Reset is synchronous
// and returns all counts, flags, state and configuration to their defaults;
// the held code point, key index and result payload are not reset.
`default_nettype none

module key_group_reorder
  import krg_pkg::*;
#(
  parameter int NUM_KEYS   = 6,
  parameter int COUNT_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [CP_W-1:0]  cfg_data,
  krg_stream_if.sink            in_ch,
  krg_stream_if.source          out_ch
);

  logic [CP_W-1:0] keys [NUM_KEYS];
  cfg_mode_t       mode;
  logic            slot_free;
  logic            emit;
  out_item_t       res;
  logic            out_valid;
  out_item_t       out_item;

  krg_cfg #(
    .NUM_KEYS (NUM_KEYS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .keys     (keys),
    .mode     (mode)
  );

  krg_seq #(
    .NUM_KEYS   (NUM_KEYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .mode      (mode),
    .in_valid  (in_ch.valid),
    .in_item   (in_ch.payload),
    .in_ready  (in_ch.ready),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res)
  );

  // The result register may be refilled in the same cycle it is drained.
  assign slot_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= res;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

`default_nettype wire

// ----- rtl/core/krg_cfg.sv -----
// Configuration register file: key code points, active key count and dedup.
// Depends on krg_pkg.
`default_nettype none

module krg_cfg
  import krg_pkg::*;
#(
  parameter int NUM_KEYS = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [CP_W-1:0] cfg_data,
  output logic [CP_W-1:0]      keys [NUM_KEYS],
  output cfg_mode_t            mode
);

  logic [USE_W-1:0] keys_in_use;
  logic             dedup_on;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    always_ff @(posedge clk) begin
      if (rst) begin
        keys[i] <= '0;
      end else if (cfg_we && cfg_idx == CFG_KEY_0 + IDX_W'(i)) begin
        keys[i] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use <= KEYS_IN_USE_RESET;
      dedup_on    <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_KEYS_IN_USE) begin
        keys_in_use <= cfg_data[USE_W-1:0];
      end
      if (cfg_idx == CFG_DEDUP_ON) begin
        dedup_on <= cfg_data[0];
      end
    end
  end

  // A count above the number of built keys means all of them.
  assign mode.active = (keys_in_use > USE_W'(NUM_KEYS)) ? USE_W'(NUM_KEYS) : keys_in_use;
  assign mode.dedup  = dedup_on;

endmodule

`default_nettype wire

// ----- rtl/core/krg_seq.sv -----
// Sequencer with one shared compare unit: scans the keys, counts key hits
// and walks the counts to emit a settled group. Depends on krg_pkg.
`default_nettype none

module krg_seq
  import krg_pkg::*;
#(
  parameter int NUM_KEYS   = 6,
  parameter int COUNT_BITS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [CP_W-1:0] keys [NUM_KEYS],
  input  wire cfg_mode_t       mode,
  input  wire logic            in_valid,
  input  wire in_item_t        in_item,
  output logic                 in_ready,
  input  wire logic            slot_free,
  output logic                 emit,
  output out_item_t            res
);

  localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  krg_state_t            state, state_next;
  logic [CP_W-1:0]       cp, cp_next;
  logic                  eos, eos_next;
  logic                  delim, delim_next;
  logic [KIW-1:0]        scan_idx, scan_idx_next;
  logic [COUNT_BITS-1:0] counts [NUM_KEYS];
  logic [COUNT_BITS-1:0] counts_next [NUM_KEYS];
  logic                  group_open, group_open_next;
  logic [KIW-1:0]        prev_idx, prev_idx_next;
  logic                  needs, needs_next;
  logic                  str_mod, str_mod_next;

  logic                  hit;
  logic                  scan_last;
  logic                  settle_last;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  later_nz;
  logic [16:0]           count_ext;
  logic [REP_W-1:0]      rep;

  // The shared unit: one key selected by the index against the held code point.
  assign hit         = (keys[scan_idx] == cp);
  assign scan_last   = (USE_W'(scan_idx) + USE_W'(1)) == mode.active;
  assign settle_last = (scan_idx == KIW'(NUM_KEYS - 1));
  assign cur_count   = counts[scan_idx];
  assign count_inc   = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
  assign count_ext   = 17'(cur_count);
  assign rep         = mode.dedup ? REP_W'(1)
                     : ((count_ext > 17'd255) ? 8'hFF : count_ext[REP_W-1:0]);

  always_comb begin
    later_nz = 1'b0;
    for (int j = 0; j < NUM_KEYS; j++) begin
      if (KIW'(j) > scan_idx && counts[j] != '0) begin
        later_nz = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      group_open <= 1'b0;
      prev_idx   <= '0;
      needs      <= 1'b0;
      str_mod    <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state      <= state_next;
      group_open <= group_open_next;
      prev_idx   <= prev_idx_next;
      needs      <= needs_next;
      str_mod    <= str_mod_next;
      counts     <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    cp       <= cp_next;
    eos      <= eos_next;
    delim    <= delim_next;
    scan_idx <= scan_idx_next;
  end

  always_comb begin
    state_next      = state;
    cp_next         = cp;
    eos_next        = eos;
    delim_next      = delim;
    scan_idx_next   = scan_idx;
    counts_next     = counts;
    group_open_next = group_open;
    prev_idx_next   = prev_idx;
    needs_next      = needs;
    str_mod_next    = str_mod;
    in_ready        = 1'b0;
    emit            = 1'b0;
    res             = '0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cp_next       = in_item.code_point;
          eos_next      = in_item.end_of_string;
          scan_idx_next = '0;
          if (mode.active == '0) begin
            delim_next = 1'b1;
            state_next = group_open ? ST_SETTLE : ST_DELIM;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          state_next = ST_UPDATE;
        end else if (scan_last) begin
          delim_next    = 1'b1;
          scan_idx_next = '0;
          state_next    = group_open ? ST_SETTLE : ST_DELIM;
        end else begin
          scan_idx_next = scan_idx + KIW'(1);
        end
      end

      ST_UPDATE: begin
        // A key earlier in the list than its predecessor marks the group.
        needs_next = group_open ? (needs | (scan_idx < prev_idx)) : 1'b0;
        if (mode.dedup && count_inc > COUNT_BITS'(1)) begin
          needs_next = 1'b1;
        end
        group_open_next        = 1'b1;
        prev_idx_next          = scan_idx;
        counts_next[scan_idx]  = count_inc;
        if (eos) begin
          delim_next    = 1'b0;
          scan_idx_next = '0;
          state_next    = ST_SETTLE;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_SETTLE: begin
        if (cur_count == '0 || slot_free) begin
          if (cur_count != '0) begin
            emit               = 1'b1;
            res.out_code_point = keys[scan_idx];
            res.repeat_res     = rep;
            res.last_of_run    = !delim && !later_nz;
            res.string_done    = !delim && !later_nz && eos;
            res.was_modified   = !delim && !later_nz && eos && (str_mod | needs);
          end
          counts_next[scan_idx] = '0;
          if (settle_last) begin
            group_open_next = 1'b0;
            needs_next      = 1'b0;
            if (delim) begin
              str_mod_next = str_mod | needs;
              state_next   = ST_DELIM;
            end else begin
              // Only a key at the end of the string settles without a delimiter.
              str_mod_next  = 1'b0;
              prev_idx_next = '0;
              state_next    = ST_IDLE;
            end
          end else begin
            scan_idx_next = scan_idx + KIW'(1);
          end
        end
      end

      ST_DELIM: begin
        if (slot_free) begin
          emit               = 1'b1;
          res.out_code_point = cp;
          res.repeat_res     = REP_W'(1);
          res.last_of_run    = 1'b1;
          res.string_done    = eos;
          res.was_modified   = eos && str_mod;
          if (eos) begin
            str_mod_next  = 1'b0;
            prev_idx_next = '0;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
